// ===== rtl/itds_pkg.sv =====
// Package for the integer to digit string converter.
// Holds the sizes, the digit glyph table, the radix clamp and the shared types.
// No dependencies.
package itds_pkg;

   // Sizes of the number and of the digit store.
   localparam int VALUE_BITS = 32;
   localparam int MAX_DIGITS = 32;

   // Field widths of the channels.
   localparam int VALUE_W = 32;
   localparam int RADIX_W = 5;
   localparam int CHAR_W  = 7;
   localparam int DIGIT_W = 4;

   // Bits of the input word that take part in the conversion.
   localparam int WORK_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

   // The divider retires this many quotient bits per cycle.
   localparam int STEP_BITS  = 4;
   localparam int DIV_STEPS  = (WORK_W + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_W      = DIV_STEPS * STEP_BITS;
   localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Digit store addressing and digit counting.
   localparam int INDEX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int COUNT_W = $clog2(MAX_DIGITS + 1);

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

   // ASCII glyphs for digit values zero to fifteen.
   localparam logic [CHAR_W-1:0] GLYPH_TABLE [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } itds_state_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } itds_div_status_type;

   // Write port of the digit store.
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] index;
      logic [DIGIT_W-1:0] digit;
   } itds_store_wr_type;

   // Request to emit the stored digits, most significant first.
   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] count;
   } itds_emit_cmd_type;

   // Bases below two are taken as two and bases above sixteen as sixteen.
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      return GLYPH_TABLE[d];
   endfunction

endpackage

// ===== rtl/itds_channels.sv =====
// Channel interfaces of the integer to digit string converter.
// One interface for the number words and one for the digit words.
// Depends on itds_pkg.
interface itds_req_if;
   logic                          valid;
   logic                          ready;
   logic [itds_pkg::VALUE_W-1:0]  value;
   logic [itds_pkg::RADIX_W-1:0]  radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink (input valid, input value, input radix, output ready);
endinterface

interface itds_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [itds_pkg::CHAR_W-1:0]  digit_char;
   logic                         last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink (input valid, input digit_char, input last, output ready);
endinterface

// ===== rtl/itds_div_unit.sv =====
// Shared divider of the integer to digit string converter.
// Restoring division of a number by the radix, several quotient bits per cycle.
// Depends on itds_pkg.
module itds_div_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [itds_pkg::WORK_W-1:0]    dividend,
   input  logic [itds_pkg::RADIX_W-1:0]   radix,
   output itds_pkg::itds_div_status_type  status,
   output logic [itds_pkg::WORK_W-1:0]    quotient,
   output logic [itds_pkg::DIGIT_W-1:0]   remainder
);

   logic [itds_pkg::DIV_W-1:0]      shift_ff, shift_in;
   logic [itds_pkg::DIGIT_W-1:0]    rem_ff, rem_in;
   logic [itds_pkg::RADIX_W-1:0]    radix_ff;
   logic [itds_pkg::STEP_CNT_W-1:0] step_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic                            last_step;

   // The shift register holds the dividend; quotient bits enter at its low end.
   always_comb begin
      logic [itds_pkg::DIV_W-1:0]   sh_v;
      logic [itds_pkg::DIGIT_W-1:0] rem_v;
      logic [itds_pkg::RADIX_W-1:0] trial;
      sh_v  = shift_ff;
      rem_v = rem_ff;
      for (int i = 0; i < itds_pkg::STEP_BITS; i++) begin
         trial = {rem_v, sh_v[itds_pkg::DIV_W-1]};
         sh_v  = {sh_v[itds_pkg::DIV_W-2:0], 1'b0};
         if (trial >= radix_ff) begin
            trial   = trial - radix_ff;
            sh_v[0] = 1'b1;
         end
         rem_v = trial[itds_pkg::DIGIT_W-1:0];
      end
      shift_in = sh_v;
      rem_in   = rem_v;
   end

   assign last_step = (step_ff == itds_pkg::STEP_CNT_W'(itds_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= itds_pkg::DIV_W'(dividend);
         rem_ff   <= '0;
         radix_ff <= radix;
         step_ff  <= '0;
      end else if (busy_ff) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
         step_ff  <= step_ff + itds_pkg::STEP_CNT_W'(1);
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shift_ff[itds_pkg::WORK_W-1:0];
   assign remainder   = rem_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_finish : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && last_step && !start) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after its last step");

   a_rem_range : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, rem_ff} < radix_ff))
      else $error("remainder not below radix");

endmodule

// ===== rtl/itds_digit_buf.sv =====
// Digit store and output stage of the integer to digit string converter.
// Keeps the remainders and sends them as ASCII words, most significant first.
// Depends on itds_pkg and itds_channels.
module itds_digit_buf (
   input  logic                          clock,
   input  logic                          reset,
   input  itds_pkg::itds_store_wr_type   store_wr,
   input  itds_pkg::itds_emit_cmd_type   emit_cmd,
   output logic                          emit_busy,
   itds_rsp_if.source                    rsp_ch
);

   logic [itds_pkg::DIGIT_W-1:0] store_ff [itds_pkg::MAX_DIGITS];
   logic [itds_pkg::INDEX_W-1:0] idx_ff;
   logic [itds_pkg::COUNT_W-1:0] remaining_ff;
   logic                         rsp_valid_ff;
   logic [itds_pkg::CHAR_W-1:0]  rsp_char_ff;
   logic                         rsp_last_ff;
   logic                         load_slot;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_ff[store_wr.index] <= store_wr.digit;
      end
   end

   assign load_slot = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_cmd.start) begin
            remaining_ff <= emit_cmd.count;
         end else if ((remaining_ff != '0) && load_slot) begin
            remaining_ff <= remaining_ff - itds_pkg::COUNT_W'(1);
         end
         if ((remaining_ff != '0) && load_slot) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_cmd.start) begin
         idx_ff <= itds_pkg::INDEX_W'(emit_cmd.count - itds_pkg::COUNT_W'(1));
      end else if ((remaining_ff != '0) && load_slot) begin
         idx_ff <= idx_ff - itds_pkg::INDEX_W'(1);
      end
      if ((remaining_ff != '0) && load_slot) begin
         rsp_char_ff <= itds_pkg::digit_to_char(store_ff[idx_ff]);
         rsp_last_ff <= (remaining_ff == itds_pkg::COUNT_W'(1));
      end
   end

   assign emit_busy         = (remaining_ff != '0) || rsp_valid_ff;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.digit_char = rsp_char_ff;
   assign rsp_ch.last       = rsp_last_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      emit_cmd.start |-> !emit_busy)
      else $error("emit started while words are still pending");

   a_last_mark : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (remaining_ff == '0)) |-> rsp_last_ff)
      else $error("final word of a number not marked last");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff && rsp_ch.ready && !emit_cmd.start) |=> !rsp_valid_ff)
      else $error("word shown after the last digit was taken");

endmodule

// ===== rtl/integer_to_digit_string.sv =====
// Integer to digit string converter: top level with the sequencer.
// Conversion: a number of D digits passes once through the shared divider per digit before
// its first word is shown; a zero value takes no divider pass.
// Throughput: the D words leave one per cycle when the sink is ready; ready returns after
// the last word is taken, rsp valid has dropped and the sequencer is back in idle.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp valid.
module integer_to_digit_string (
   input  logic       clock,
   input  logic       reset,
   itds_req_if.sink   req_ch,
   itds_rsp_if.source rsp_ch
);

   // Sequencer state, the base in use and the count of digits found so far.
   itds_pkg::itds_state_type     state_ff, state_in;
   logic [itds_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic [itds_pkg::COUNT_W-1:0] count_ff, count_in;

   // Connections to the shared divider and the digit buffer.
   logic                          div_start;
   logic [itds_pkg::WORK_W-1:0]   div_dividend;
   logic [itds_pkg::RADIX_W-1:0]  div_radix;
   itds_pkg::itds_div_status_type div_status;
   logic [itds_pkg::WORK_W-1:0]   div_quotient;
   logic [itds_pkg::DIGIT_W-1:0]  div_remainder;
   itds_pkg::itds_store_wr_type   store_wr;
   itds_pkg::itds_emit_cmd_type   emit_cmd;
   logic                          emit_busy;

   logic                          req_accept;
   logic [itds_pkg::WORK_W-1:0]   req_work;
   logic [itds_pkg::COUNT_W-1:0]  count_next;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign req_work   = req_ch.value[itds_pkg::WORK_W-1:0];
   assign count_next = count_ff + itds_pkg::COUNT_W'(1);

   // The divider reloads from the input word when a number arrives and from
   // its own quotient for every further digit.
   assign div_dividend = (state_ff == itds_pkg::ST_IDLE) ? req_work : div_quotient;
   assign div_radix    = (state_ff == itds_pkg::ST_IDLE) ?
                         itds_pkg::clamp_radix(req_ch.radix) : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itds_pkg::ST_IDLE;
         radix_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         count_ff <= count_in;
      end
   end

   // Each divider pass yields one remainder, which is stored at the current
   // count, least significant digit first. Division ends when the quotient
   // reaches zero or the store is full; then the buffer emits the digits
   // from the highest index down, so no leading zeros ever appear.
   always_comb begin
      state_in       = state_ff;
      radix_in       = radix_ff;
      count_in       = count_ff;
      req_ch.ready   = 1'b0;
      div_start      = 1'b0;
      store_wr.en    = 1'b0;
      store_wr.index = count_ff[itds_pkg::INDEX_W-1:0];
      store_wr.digit = div_remainder;
      emit_cmd.start = 1'b0;
      emit_cmd.count = count_next;
      unique case (state_ff)
         itds_pkg::ST_IDLE: begin
            // Ready is always high while idle, so a valid word is taken here.
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               radix_in = itds_pkg::clamp_radix(req_ch.radix);
               count_in = '0;
               if (req_work == '0) begin
                  // A zero value is the single digit zero.
                  store_wr.en    = 1'b1;
                  store_wr.index = '0;
                  store_wr.digit = '0;
                  emit_cmd.start = 1'b1;
                  emit_cmd.count = itds_pkg::COUNT_W'(1);
                  state_in       = itds_pkg::ST_EMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = itds_pkg::ST_DIVIDE;
               end
            end
         end
         itds_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               store_wr.en = 1'b1;
               if ((div_quotient == '0) ||
                   (count_next == itds_pkg::COUNT_W'(itds_pkg::MAX_DIGITS))) begin
                  emit_cmd.start = 1'b1;
                  state_in       = itds_pkg::ST_EMIT;
               end else begin
                  div_start = 1'b1;
                  count_in  = count_next;
               end
            end
         end
         itds_pkg::ST_EMIT: begin
            if (!emit_busy) begin
               state_in = itds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itds_pkg::ST_IDLE;
         end
      endcase
   end

   itds_div_unit u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_radix),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   itds_digit_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .store_wr  (store_wr),
      .emit_cmd  (emit_cmd),
      .emit_busy (emit_busy),
      .rsp_ch    (rsp_ch)
   );

   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != itds_pkg::ST_IDLE))
      else $error("sequencer stayed idle after accepting a number");

   a_words_in_emit : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (state_ff == itds_pkg::ST_EMIT))
      else $error("digit word shown outside the emit phase");

   a_divider_active : assert property (@(posedge clock) disable iff (reset)
      (state_ff == itds_pkg::ST_DIVIDE) |-> (div_status.busy || div_status.done))
      else $error("divide phase with an idle divider");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == itds_pkg::ST_DIVIDE) |->
      (count_ff < itds_pkg::COUNT_W'(itds_pkg::MAX_DIGITS)))
      else $error("digit count ran past the store");

endmodule
